[design/mhbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhbt_pkg: shared types and constants of the ball tracker.
// Holds the sizes, register indexes, controller commands and a helper function.
// ----------------------------------------------------------------------------
package mhbt_pkg;

    localparam int MAX_HYPOTHESES = 64;
    localparam int HYP_IDX_W = $clog2(MAX_HYPOTHESES);
    localparam int HYP_CNT_W = $clog2(MAX_HYPOTHESES + 1);
    // One stored entry: valid, x, y, certainty.
    localparam int HYP_WORD_W = 49;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LIMIT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_FACTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELETE_THRESHOLD = 2'd3;

    localparam logic [15:0] RST_REGION_LIMIT_X = 16'd0;
    localparam logic [14:0] RST_MERGE_RADIUS = 15'd33;
    localparam logic [15:0] RST_KEEP_FACTOR = 16'd52016;
    localparam logic [15:0] RST_DELETE_THRESHOLD = 16'd1311;

    typedef struct packed {
        logic signed [15:0] obs_x;
        logic signed [15:0] obs_y;
        logic [15:0] obs_confidence;
        logic frame_empty;
        logic frame_last;
    } obs_t;

    typedef struct packed {
        logic signed [15:0] ball_x;
        logic signed [15:0] ball_y;
        logic [15:0] ball_certainty;
    } ball_t;

    typedef struct packed {
        logic valid;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0] cert;
    } hyp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic take_obs;      // fold the accepted observation into the frame best
        logic clear_pass;    // write reset contents to addr
        logic scan_start;    // start a merge/decay/top scan
        logic scan_find;     // with scan_start: the scan only searches for the top
        logic scan_step;     // process the read entry
        logic place;         // write the new hypothesis
        logic load_result;   // capture the result
        logic [HYP_IDX_W-1:0] addr;
    } ctl_cmd_t;

    typedef struct packed {
        logic best_have;
    } ctl_stat_t;

    // Q0.16 product with round half up; both operands may be exactly one.
    function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
        logic [34:0] p;
        p = 35'(a) * 35'(b) + 35'd32768;
        return p[32:16];
    endfunction

endpackage
`default_nettype wire

[design/mhbt_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhbt_stream_if: valid/ready channel.
// Carries one request of a generic payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface mhbt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/mhbt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhbt_ram: generic simple dual port RAM.
// One write and one read per cycle at separate addresses, read data registered.
// ----------------------------------------------------------------------------
module mhbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Storage with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/mhbt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhbt_datapath: hypothesis store and arithmetic.
// Keeps the frame best, the registers, and scans the hypothesis memory.
// ----------------------------------------------------------------------------
module mhbt_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mhbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mhbt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  mhbt_pkg::obs_t                       obs,
    input  mhbt_pkg::ctl_cmd_t                   cmd,
    output mhbt_pkg::ctl_stat_t                  stat,
    output logic [mhbt_pkg::HYP_IDX_W-1:0]       place_addr,
    output mhbt_pkg::ball_t                      result
);
    localparam int IW = mhbt_pkg::HYP_IDX_W;

    logic signed [15:0] region_reg;
    logic [14:0] radius_reg;
    logic [15:0] keep_reg;
    logic [15:0] thresh_reg;
    logic best_have_reg;
    logic signed [15:0] best_x_reg;
    logic signed [15:0] best_y_reg;
    logic [15:0] best_conf_reg;
    logic [16:0] prod_reg;
    logic [16:0] prod_next;
    logic have_free_reg;
    logic [IW-1:0] free_reg;
    logic [IW-1:0] weak_reg;
    logic [15:0] weak_cert_reg;
    logic top_have_reg;
    mhbt_pkg::ball_t top_reg;
    mhbt_pkg::ball_t result_reg;
    logic [29:0] r2_reg;
    logic [IW-1:0] addr_d_reg;
    logic step_d_reg;
    logic find_only_reg;

    logic we;
    logic [mhbt_pkg::HYP_WORD_W-1:0] wdata;
    logic [mhbt_pkg::HYP_WORD_W-1:0] rdata;
    mhbt_pkg::hyp_t rd;
    mhbt_pkg::hyp_t upd;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [33:0] d2;
    logic merge;
    logic [16:0] dec;
    logic [16:0] pk;
    logic [15:0] new_cert;
    logic better;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= mhbt_pkg::RST_REGION_LIMIT_X;
            radius_reg <= mhbt_pkg::RST_MERGE_RADIUS;
            keep_reg <= mhbt_pkg::RST_KEEP_FACTOR;
            thresh_reg <= mhbt_pkg::RST_DELETE_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mhbt_pkg::REG_REGION_LIMIT_X: region_reg <= cfg_data;
                mhbt_pkg::REG_MERGE_RADIUS: radius_reg <= cfg_data[14:0];
                mhbt_pkg::REG_KEEP_FACTOR: keep_reg <= cfg_data;
                mhbt_pkg::REG_DELETE_THRESHOLD: thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rd = rdata;

    // Squared distance of the read entry to the frame best; the search-only
    // scan leaves every entry as it is.
    always_comb
    begin
        dx = 17'(best_x_reg) - 17'(rd.x);
        dy = 17'(best_y_reg) - 17'(rd.y);
        d2 = 34'(dx * dx) + 34'(dy * dy);
        merge = !find_only_reg && best_have_reg && rd.valid && (d2 < 34'(r2_reg));
        dec = mhbt_pkg::qmul(17'(rd.cert), 17'(keep_reg));
        upd = rd;
        if (rd.valid && !find_only_reg)
        begin
            if (merge)
            begin
                upd.valid = 1'b0;
            end
            else
            begin
                upd.cert = dec[15:0];
                if (best_have_reg && dec[15:0] < thresh_reg)
                begin
                    upd.valid = 1'b0;
                end
            end
        end
        prod_next = merge ? mhbt_pkg::qmul(prod_reg, 17'h10000 - 17'(rd.cert))
                          : prod_reg;
        pk = mhbt_pkg::qmul(prod_reg, 17'(keep_reg));
        new_cert = (pk == 17'd0) ? 16'hFFFF : 16'(17'h10000 - pk);
    end

    // Memory write selection.
    always_comb
    begin
        we = 1'b0;
        wdata = '0;
        if (cmd.clear_pass)
        begin
            we = 1'b1;
            wdata = (cmd.addr == '0) ? {1'b1, 32'd0, mhbt_pkg::RST_DELETE_THRESHOLD}
                                     : '0;
        end
        else if (cmd.place)
        begin
            we = 1'b1;
            wdata = {1'b1, best_x_reg, best_y_reg, new_cert};
        end
        else if (step_d_reg && !find_only_reg)
        begin
            we = 1'b1;
            wdata = upd;
        end
    end

    mhbt_ram #(
        .WIDTH(mhbt_pkg::HYP_WORD_W),
        .DEPTH(mhbt_pkg::MAX_HYPOTHESES)
    ) u_ram (
        .clk(clk),
        .we(we),
        .waddr(step_d_reg ? addr_d_reg : cmd.addr),
        .wdata(wdata),
        .raddr(cmd.addr),
        .rdata(rdata)
    );

    // Result ordering: certainty, then x, then y.
    assign better = !top_have_reg || (upd.cert > top_reg.ball_certainty)
        || (upd.cert == top_reg.ball_certainty && (upd.x > top_reg.ball_x
        || (upd.x == top_reg.ball_x && upd.y > top_reg.ball_y)));

    // Frame best and scan accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_have_reg <= 1'b0;
            best_x_reg <= '0;
            best_y_reg <= '0;
            best_conf_reg <= '0;
            step_d_reg <= 1'b0;
            top_have_reg <= 1'b0;
            have_free_reg <= 1'b0;
            find_only_reg <= 1'b0;
        end
        else
        begin
            step_d_reg <= cmd.scan_step;
            if (cmd.take_obs && !obs.frame_empty && obs.obs_x < region_reg
                && obs.obs_confidence > best_conf_reg)
            begin
                best_have_reg <= 1'b1;
                best_x_reg <= obs.obs_x;
                best_y_reg <= obs.obs_y;
                best_conf_reg <= obs.obs_confidence;
            end
            if (cmd.scan_start)
            begin
                top_have_reg <= 1'b0;
                have_free_reg <= 1'b0;
                find_only_reg <= cmd.scan_find;
            end
            if (step_d_reg)
            begin
                if (upd.valid && better)
                begin
                    top_have_reg <= 1'b1;
                end
                if (!upd.valid && !have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                end
            end
            if (cmd.load_result)
            begin
                best_have_reg <= 1'b0;
                best_x_reg <= '0;
                best_y_reg <= '0;
                best_conf_reg <= '0;
            end
        end
    end

    // Payload registers of the scan.
    always_ff @(posedge clk)
    begin
        addr_d_reg <= cmd.addr;
        if (cmd.scan_start)
        begin
            prod_reg <= 17'h10000;
            r2_reg <= 30'(radius_reg) * 30'(radius_reg);
        end
        if (step_d_reg)
        begin
            prod_reg <= prod_next;
            if (upd.valid && better)
            begin
                top_reg <= '{upd.x, upd.y, upd.cert};
            end
            if (!upd.valid && !have_free_reg)
            begin
                free_reg <= addr_d_reg;
            end
            if (addr_d_reg == '0 || upd.cert < weak_cert_reg)
            begin
                weak_reg <= addr_d_reg;
                weak_cert_reg <= upd.cert;
            end
        end
        if (cmd.load_result)
        begin
            result_reg <= top_have_reg ? top_reg : '0;
        end
    end

    assign stat.best_have = best_have_reg;
    assign place_addr = have_free_reg ? free_reg : weak_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

[design/mhbt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhbt_ctrl: sequencer of the tracker.
// Clears the store after reset, takes requests and drives the frame-end scans.
// ----------------------------------------------------------------------------
module mhbt_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_last,
    output logic                             in_ready,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    input  mhbt_pkg::ctl_stat_t              stat,
    input  wire logic [mhbt_pkg::HYP_IDX_W-1:0] place_addr,
    output mhbt_pkg::ctl_cmd_t               cmd
);
    localparam int IW = mhbt_pkg::HYP_IDX_W;
    localparam int CW = mhbt_pkg::HYP_CNT_W;
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN1 = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_SCAN2 = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;
    localparam logic [2:0] S_DRAIN2 = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic cnt_end;

    assign cnt_end = (cnt_reg == CW'(mhbt_pkg::MAX_HYPOTHESES - 1));
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.addr = cnt_reg[IW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_pass = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cnt_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take_obs = 1'b1;
                    if (in_last)
                    begin
                        cmd.scan_start = 1'b1;
                        cnt_next = '0;
                        state_next = S_SCAN1;
                    end
                end
            end
            S_SCAN1, S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cnt_next = '0;
                    state_next = (state_reg == S_SCAN1) ? S_DRAIN : S_DRAIN2;
                end
            end
            S_DRAIN:
            begin
                // Last write-back lands this cycle.
                if (stat.best_have)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PLACE:
            begin
                cmd.place = 1'b1;
                cmd.addr = place_addr;
                cmd.scan_start = 1'b1;
                cmd.scan_find = 1'b1;
                cnt_next = '0;
                state_next = S_SCAN2;
            end
            S_DRAIN2:
            begin
                // Last entry of the search is compared this cycle.
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.load_result = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The store is never touched by two commands at once.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clear_pass, cmd.place, cmd.scan_step}) <= 1)
        else $error("conflicting store commands");
    // No request is taken while a result waits.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !cmd.take_obs)
        else $error("request taken while result pending");
    // A result appears only after the output state.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without scan");
endmodule
`default_nettype wire

[design/multi_hypothesis_ball_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_hypothesis_ball_tracker_top: ball tracker with up to 64 hypotheses.
// Top level joining the sequencer and the hypothesis datapath.
// ----------------------------------------------------------------------------
// After reset the store is cleared entry by entry, during which no request is
// taken. An item that does not end a frame leaves the block ready for the next.
// An item that ends a frame starts a scan of all 64 entries through the memory
// (merge, decay, result search); if an observation was chosen, the new
// hypothesis is written and a second 64-entry scan finds the result. The
// result is registered and held until taken; no request is taken while the
// result waits or while a scan runs.
module multi_hypothesis_ball_tracker_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mhbt_stream_if.sink                          obs_in,
    mhbt_stream_if.source                        ball_out,
    input  wire logic                            cfg_we,
    input  wire logic [mhbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mhbt_pkg::CFG_DATA_W-1:0] cfg_data
);
    mhbt_pkg::ctl_cmd_t cmd;
    mhbt_pkg::ctl_stat_t stat;
    mhbt_pkg::obs_t obs;
    logic [mhbt_pkg::HYP_IDX_W-1:0] place_addr;

    assign obs = obs_in.data;

    mhbt_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(obs_in.valid),
        .in_last(obs.frame_last),
        .in_ready(obs_in.ready),
        .out_valid(ball_out.valid),
        .out_ready(ball_out.ready),
        .stat(stat),
        .place_addr(place_addr),
        .cmd(cmd)
    );

    mhbt_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .obs(obs),
        .cmd(cmd),
        .stat(stat),
        .place_addr(place_addr),
        .result(ball_out.data)
    );
endmodule
`default_nettype wire

[test/mhbt_tracker_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhbt_tracker_checker: prediction and comparison for the ball tracker.
// Follows register writes and accepted observation requests, keeps its own
// copy of the hypothesis store and compares every accepted ball report with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module mhbt_tracker_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            obs_valid,
    input  logic                            obs_ready,
    input  mhbt_pkg::obs_t                  obs_data,
    input  logic                            ball_valid,
    input  logic                            ball_ready,
    input  mhbt_pkg::ball_t                 ball_data,
    input  logic                            cfg_we,
    input  logic [mhbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mhbt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              reports_pending
);

    localparam int N_HYP = mhbt_pkg::MAX_HYPOTHESES;

    // Shadow configuration.
    logic signed [15:0] limit_x;
    logic [14:0]        radius;
    logic [15:0]        keep;
    logic [15:0]        del_thr;

    // Shadow hypothesis store and running frame best.
    logic               hv [N_HYP];
    logic signed [15:0] hx [N_HYP];
    logic signed [15:0] hy [N_HYP];
    logic [15:0]        hc [N_HYP];
    logic               fb_have;
    logic signed [15:0] fb_x;
    logic signed [15:0] fb_y;
    logic [15:0]        fb_conf;

    mhbt_pkg::ball_t report_queue[$];

    assign reports_pending = report_queue.size();

    // Q0.16 product rounded half up.
    function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    // Decay every live hypothesis, optionally dropping the weak ones.
    task automatic decay_store(input bit drop);
        for (int i = 0; i < N_HYP; i++)
        begin
            if (hv[i])
            begin
                hc[i] = 16'(q16_mul(hc[i], keep));
                if (drop && hc[i] < del_thr)
                    hv[i] = 1'b0;
            end
        end
    endtask

    // Frame-end update: merge near the chosen observation, decay, place; with none chosen, only decay.
    task automatic update_frame();
        longint unsigned miss_prod;
        longint unsigned new_cert;
        longint unsigned r2;
        longint          dx;
        longint          dy;
        bit              near [N_HYP];
        int              slot;
        miss_prod = 65536;
        r2 = longint'(radius) * longint'(radius);
        slot = -1;
        if (!fb_have)
        begin
            decay_store(1'b0);
            return;
        end
        for (int i = 0; i < N_HYP; i++)
        begin
            near[i] = 1'b0;
            if (hv[i])
            begin
                dx = longint'(fb_x) - longint'(hx[i]);
                dy = longint'(fb_y) - longint'(hy[i]);
                if (longint'(dx * dx + dy * dy) < longint'(r2))
                begin
                    miss_prod = q16_mul(miss_prod, 65536 - hc[i]);
                    near[i] = 1'b1;
                end
            end
        end
        for (int i = 0; i < N_HYP; i++)
            if (near[i])
                hv[i] = 1'b0;
        decay_store(1'b1);
        new_cert = 65536 - q16_mul(miss_prod, keep);
        if (new_cert > 65535)
            new_cert = 65535;
        for (int i = 0; i < N_HYP; i++)
        begin
            if (!hv[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0)
        begin
            slot = 0;
            for (int i = 1; i < N_HYP; i++)
                if (hc[i] < hc[slot])
                    slot = i;
        end
        hv[slot] = 1'b1;
        hx[slot] = fb_x;
        hy[slot] = fb_y;
        hc[slot] = 16'(new_cert);
    endtask

    // Fold one observation request into the frame and, at frame end, predict the report.
    task automatic take_observation(input mhbt_pkg::obs_t o);
        mhbt_pkg::ball_t rep;
        int              top;
        top = -1;
        if (!o.frame_empty && o.obs_x < limit_x && o.obs_confidence > fb_conf)
        begin
            fb_have = 1'b1;
            fb_x    = o.obs_x;
            fb_y    = o.obs_y;
            fb_conf = o.obs_confidence;
        end
        if (o.frame_last)
        begin
            update_frame();
            fb_have = 1'b0;
            fb_x    = '0;
            fb_y    = '0;
            fb_conf = '0;
            // Most certain entry; ties go to larger x, then larger y.
            for (int i = 0; i < N_HYP; i++)
            begin
                if (hv[i] && (top < 0 || hc[i] > hc[top] ||
                    (hc[i] == hc[top] && (hx[i] > hx[top] ||
                    (hx[i] == hx[top] && hy[i] > hy[top])))))
                    top = i;
            end
            if (top < 0)
                rep = '0;
            else
                rep = '{ball_x: hx[top], ball_y: hy[top], ball_certainty: hc[top]};
            report_queue.insert(report_queue.size(), rep);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mhbt_pkg::ball_t want;
        if (!rst_n)
        begin
            limit_x = mhbt_pkg::RST_REGION_LIMIT_X;
            radius  = mhbt_pkg::RST_MERGE_RADIUS;
            keep    = mhbt_pkg::RST_KEEP_FACTOR;
            del_thr = mhbt_pkg::RST_DELETE_THRESHOLD;
            for (int i = 0; i < N_HYP; i++)
            begin
                hv[i] = 1'b0;
                hx[i] = '0;
                hy[i] = '0;
                hc[i] = '0;
            end
            hv[0] = 1'b1;
            hc[0] = mhbt_pkg::RST_DELETE_THRESHOLD;
            fb_have = 1'b0;
            fb_x    = '0;
            fb_y    = '0;
            fb_conf = '0;
            report_queue.delete();
            mismatch_count = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    mhbt_pkg::REG_REGION_LIMIT_X:   limit_x = cfg_data;
                    mhbt_pkg::REG_MERGE_RADIUS:     radius  = cfg_data[14:0];
                    mhbt_pkg::REG_KEEP_FACTOR:      keep    = cfg_data;
                    mhbt_pkg::REG_DELETE_THRESHOLD: del_thr = cfg_data;
                    default: ;
                endcase
            end
            if (obs_valid && obs_ready)
                take_observation(obs_data);
            // Report comparison.
            if (ball_valid && ball_ready)
            begin
                if (report_queue.size() == 0)
                begin
                    $error("ball report with none predicted: x=%0d y=%0d cert=%0d",
                           ball_data.ball_x, ball_data.ball_y, ball_data.ball_certainty);
                    mismatch_count++;
                end
                else
                begin
                    want = report_queue.pop_front();
                    if (ball_data.ball_x !== want.ball_x)
                    begin
                        $error("ball_x expected %0d actual %0d", want.ball_x, ball_data.ball_x);
                        mismatch_count++;
                    end
                    if (ball_data.ball_y !== want.ball_y)
                    begin
                        $error("ball_y expected %0d actual %0d", want.ball_y, ball_data.ball_y);
                        mismatch_count++;
                    end
                    if (ball_data.ball_certainty !== want.ball_certainty)
                    begin
                        $error("ball_certainty expected %0d actual %0d",
                               want.ball_certainty, ball_data.ball_certainty);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

[test/tb_multi_hypothesis_ball_tracker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_hypothesis_ball_tracker_top: testbench of the ball tracker.
// Sends directed and random observation frames under several register
// settings with random stalls on both channels; the checker predicts every
// ball report and the verdict is given at the end.
// ----------------------------------------------------------------------------
module tb_multi_hypothesis_ball_tracker_top;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mhbt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mhbt_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              mismatch_count;
    int                              reports_pending;

    // Stall control shared by the stimulus process and the report sink.
    bit steady;
    bit long_hold_req;

    // Cluster centres so that observations land near stored hypotheses.
    logic signed [15:0] centre_x [8];
    logic signed [15:0] centre_y [8];

    mhbt_stream_if #(.T(mhbt_pkg::obs_t))  obs_if ();
    mhbt_stream_if #(.T(mhbt_pkg::ball_t)) ball_if ();

    multi_hypothesis_ball_tracker_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .obs_in   (obs_if.sink),
        .ball_out (ball_if.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    mhbt_tracker_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .obs_valid      (obs_if.valid),
        .obs_ready      (obs_if.ready),
        .obs_data       (obs_if.data),
        .ball_valid     (ball_if.valid),
        .ball_ready     (ball_if.ready),
        .ball_data      (ball_if.data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .reports_pending(reports_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Report sink: random stall bursts, one long hold on request.
    initial
    begin
        ball_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                ball_if.ready = 1'b0;
                repeat (600) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                ball_if.ready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
                ball_if.ready = 1'b1;
        end
    end

    task automatic send_obs(input mhbt_pkg::obs_t o);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            obs_if.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        obs_if.valid = 1'b1;
        obs_if.data  = o;
        do
            @(posedge clk);
        while (!obs_if.ready);
        @(negedge clk);
        obs_if.valid = 1'b0;
    endtask

    task automatic send_directed(input logic signed [15:0] x, input logic signed [15:0] y,
                                 input logic [15:0] c, input bit empty, input bit last);
        send_obs('{obs_x: x, obs_y: y, obs_confidence: c, frame_empty: empty,
                   frame_last: last});
    endtask

    // Wait until all reports are in and the block has gone quiet.
    task automatic drain();
        while (reports_pending != 0)
            @(negedge clk);
        repeat (160) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mhbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] lim, input logic [15:0] rad,
                            input logic [15:0] kf, input logic [15:0] thr);
        drain();
        write_reg(mhbt_pkg::REG_REGION_LIMIT_X, lim);
        write_reg(mhbt_pkg::REG_MERGE_RADIUS, rad);
        write_reg(mhbt_pkg::REG_KEEP_FACTOR, kf);
        write_reg(mhbt_pkg::REG_DELETE_THRESHOLD, thr);
    endtask

    function automatic mhbt_pkg::obs_t make_obs(input bit last, input int spread);
        mhbt_pkg::obs_t o;
        int             k;
        k = $urandom_range(0, 7);
        o.obs_x = centre_x[k] + 16'($signed($urandom_range(0, 2 * spread)) - spread);
        o.obs_y = centre_y[k] + 16'($signed($urandom_range(0, 2 * spread)) - spread);
        if ($urandom_range(0, 9) == 0)
        begin
            o.obs_x = 16'($urandom);
            o.obs_y = 16'($urandom);
        end
        case ($urandom_range(0, 19))
            0:       o.obs_confidence = '0;
            1:       o.obs_confidence = 16'hFFFF;
            default: o.obs_confidence = 16'($urandom);
        endcase
        o.frame_empty = ($urandom_range(0, 19) == 0);
        o.frame_last  = last;
        return o;
    endfunction

    // Frames of random observations around the centres.
    task automatic run_frames(input int n_items, input int spread);
        int sent;
        int len;
        sent = 0;
        for (int k = 0; k < 8; k++)
        begin
            centre_x[k] = 16'($urandom);
            centre_y[k] = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
            begin
                centre_x[k] = 16'($signed($urandom_range(0, 400)) - 300);
                centre_y[k] = 16'($signed($urandom_range(0, 400)) - 200);
            end
        end
        while (sent < n_items)
        begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                send_obs(make_obs(i == len - 1, spread));
            sent += len;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        obs_if.valid  = 1'b0;
        obs_if.data   = '0;
        steady        = 1'b0;
        long_hold_req = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed frames under the reset settings.
        send_directed(-16'sd32768, 16'sd32767, 16'hFFFF, 1'b0, 1'b1);
        send_directed(-16'sd32768, 16'sd32767, 16'hFFFF, 1'b0, 1'b1);
        send_directed(-16'sd5, -16'sd32768, 16'd0, 1'b0, 1'b1);
        send_directed(-16'sd10, 16'sd10, 16'd1000, 1'b0, 1'b0);
        send_directed(-16'sd20, 16'sd20, 16'd1000, 1'b0, 1'b0);
        send_directed(16'sd0, 16'sd0, 16'd9000, 1'b0, 1'b0);
        send_directed(16'sd32767, 16'sd5, 16'd9000, 1'b0, 1'b1);
        send_directed(-16'sd1, -16'sd1, 16'hFFFF, 1'b1, 1'b0);
        send_directed(16'sd0, 16'sd0, 16'd0, 1'b1, 1'b1);
        send_directed(-16'sd12, 16'sd12, 16'd40000, 1'b0, 1'b1);
        send_directed(-16'sd12, 16'sd12, 16'd40000, 1'b0, 1'b1);
        send_directed(-16'sd30, 16'sd30, 16'd65535, 1'b0, 1'b1);

        // Extremes: widest region and merge radius, highest keep factor, no deletion.
        set_regs(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
        send_directed(16'sd32766, 16'sd32767, 16'hFFFF, 1'b0, 1'b1);
        send_directed(-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0, 1'b1);
        send_directed(16'sd100, -16'sd100, 16'hFFFF, 1'b0, 1'b1);
        send_directed(16'sd100, -16'sd100, 16'hFFFF, 1'b1, 1'b1);
        run_frames(80, 50);

        // Nothing is chosen: all hypotheses only decay.
        set_regs(16'h8000, 16'd0, 16'd30000, 16'hFFFF);
        run_frames(40, 30);

        // Zero keep factor with the highest delete threshold.
        set_regs(16'h7FFF, 16'd100, 16'd0, 16'hFFFF);
        run_frames(60, 30);

        // No merging and no loss: the store fills and replaces its weakest.
        set_regs(16'h7FFF, 16'd0, 16'hFFFF, 16'd0);
        for (int i = 0; i < 90; i++)
            send_directed(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                          1'b0, 1'b1);
        set_regs(16'h7FFF, 16'd40, 16'd65000, 16'd0);
        run_frames(80, 30);

        // Long hold on the report side while requests keep coming.
        long_hold_req = 1'b1;
        run_frames(60, 30);
        set_regs(16'h0000, 16'd33, 16'd52016, 16'd1311);
        run_frames(100, 30);

        // Random settings.
        for (int p = 0; p < 6; p++)
        begin
            set_regs(16'($urandom), 16'($urandom_range(0, 32767) >> $urandom_range(0, 8)),
                     16'($urandom_range(40000, 65535)), 16'($urandom_range(0, 6000)));
            run_frames(90, $urandom_range(5, 200));
        end

        // Closing stretch without idling.
        set_regs(16'h7FFF, 16'd60, 16'd60000, 16'd2000);
        steady = 1'b1;
        run_frames(120, 40);

        drain();
        if (mismatch_count == 0 && reports_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
design/mhbt_pkg.sv
design/mhbt_stream_if.sv
design/mhbt_ram.sv
design/mhbt_datapath.sv
design/mhbt_ctrl.sv
design/multi_hypothesis_ball_tracker_top.sv
test/mhbt_tracker_checker.sv
test/tb_multi_hypothesis_ball_tracker_top.sv
